// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the scaler RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/pnns_pkg.sv -----
// Shared types, codes, constants and color helpers of the palette scaler.
package pnns_pkg;

    // Default store sizes.
    localparam int SOURCE_PIXELS_DEF   = 65536;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Width of a linear source address before it is reduced to the store size.
    localparam int LIN_W = 21;

    // Input transaction actions.
    localparam logic [1:0] ACT_PAL_WR = 2'd0;
    localparam logic [1:0] ACT_SRC_WR = 2'd1;
    localparam logic [1:0] ACT_PIXEL  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_OUT_FORMAT = 3'd4;

    // Output formats.
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_WORD32 = 1'b1;

    // Dimension limits and reset values.
    localparam logic [10:0] SRC_DIM_MAX   = 11'd1024;
    localparam logic [12:0] DST_DIM_MAX   = 13'd4096;
    localparam logic [10:0] SRC_WIDTH_RST  = 11'd320;
    localparam logic [10:0] SRC_HEIGHT_RST = 11'd200;
    localparam logic [12:0] DST_WIDTH_RST  = 13'd640;
    localparam logic [12:0] DST_HEIGHT_RST = 13'd400;

    // Palette access from the sequencer to the palette unit.
    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [31:0] wr_data;
        logic        rd_en;
        logic [7:0]  rd_idx;
    } t_pal_req;

    // Zero reads as one, anything above the limit as the limit.
    function automatic logic [10:0] clamp_src_dim(input logic [10:0] v);
        if (v == 11'd0) begin
            return 11'd1;
        end
        return (v > SRC_DIM_MAX) ? SRC_DIM_MAX : v;
    endfunction

    function automatic logic [12:0] clamp_dst_dim(input logic [12:0] v);
        if (v == 13'd0) begin
            return 13'd1;
        end
        return (v > DST_DIM_MAX) ? DST_DIM_MAX : v;
    endfunction

    // Palette entry that was never written holds a gray level.
    function automatic logic [31:0] gray_ramp(input logic [7:0] idx);
        return {8'd0, idx, idx, idx};
    endfunction

    // Top bits of each channel packed as 5-6-5.
    function automatic logic [31:0] pack_rgb565(input logic [31:0] color);
        return {16'd0, color[23:19], color[15:10], color[7:3]};
    endfunction

endpackage

// ----- hw/rtl/pnns_palette.sv -----
// Palette memory with per-entry valid bits, gray-ramp defaults and output formatting.
module pnns_palette import pnns_pkg::*; #(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pal_req    i_req,
    input  logic        i_out_format,
    output logic [31:0] o_pixel
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [31:0]                r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_vld;
    logic [31:0]                r_rd_data;
    logic                       r_rd_vld;
    logic                       r_rd_hit;
    logic [7:0]                 r_rd_idx;
    logic                       w_wr_hit;
    logic                       w_rd_hit;
    logic [31:0]                w_color;

    // Entries at or above the palette size are ignored on write and read as black.
    assign w_wr_hit = i_req.wr_en && (17'(i_req.wr_addr) < 17'(PALETTE_ENTRIES));
    assign w_rd_hit = 9'(i_req.rd_idx) < 9'(PALETTE_ENTRIES);

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_hit) begin
            r_mem[i_req.wr_addr[PAL_AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_idx[PAL_AW-1:0]];
            r_rd_vld  <= r_vld[i_req.rd_idx[PAL_AW-1:0]];
            r_rd_hit  <= w_rd_hit;
            r_rd_idx  <= i_req.rd_idx;
        end
    end

    // Valid bits: reset returns every entry to its gray level at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr_hit) begin
            r_vld[i_req.wr_addr[PAL_AW-1:0]] <= 1'b1;
        end
    end

    // Select the stored color, the default ramp or black, then format it.
    always_comb begin
        if (!r_rd_hit) begin
            w_color = 32'd0;
        end else if (r_rd_vld) begin
            w_color = r_rd_data;
        end else begin
            w_color = gray_ramp(r_rd_idx);
        end
        o_pixel = (i_out_format == FMT_WORD32) ? w_color : pack_rgb565(w_color);
    end

endmodule

// ----- hw/rtl/palette_nearest_neighbor_scaler.sv -----
// Indexed-color nearest-neighbor scaler: source index memory, walk sequencer, palette.
// Pixel request: busy from start through settling, M reduction steps, palette read, emit;
// the strobe rises as busy drops. Settling subtracts once per cycle per axis, up to 1024
// times when shrinking hard. Palette write: no busy. M is 0 for a power-of-two store, else
// LIN_W - clog2(SOURCE_PIXELS) + 1. Source write: busy through reduction and the write.
// Reset (synchronous): walk at the first pixel, registers at defaults, palette a gray ramp.
`include "assert_macros.svh"

module palette_nearest_neighbor_scaler import pnns_pkg::*; #(
    parameter int SOURCE_PIXELS   = SOURCE_PIXELS_DEF,
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic [31:0] o_pixel,
    output logic        o_end_of_row,
    output logic        o_end_of_frame
);

    localparam int SRC_AW    = $clog2(SOURCE_PIXELS);
    localparam bit POW2      = (SOURCE_PIXELS & (SOURCE_PIXELS - 1)) == 0;
    localparam int MOD_STEPS = POW2 ? 0 : LIN_W - SRC_AW + 1;
    localparam int STEP_W    = $clog2(LIN_W + 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETTLE = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_PAL    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [10:0]       r_sw;
    logic [10:0]       r_sh;
    logic [12:0]       r_dw;
    logic [12:0]       r_dh;
    logic              r_out_fmt;
    logic [9:0]        r_src_col;
    logic [9:0]        r_src_row;
    logic [12:0]       r_col_err;
    logic [12:0]       r_row_err;
    logic [11:0]       r_dst_col;
    logic [11:0]       r_dst_row;
    logic              r_is_wr;
    logic [7:0]        r_wbyte;
    logic [LIN_W-1:0]  r_lin;
    logic [STEP_W-1:0] r_step;
    logic [7:0]        r_src_mem [SOURCE_PIXELS];
    logic [7:0]        r_src_q;
    logic              r_strobe;
    logic [31:0]       r_pixel;
    logic              r_eor;
    logic              r_eof;

    logic              w_accept;
    logic              w_cfg_wr;
    logic              w_row_more;
    logic              w_col_more;
    logic [LIN_W-1:0]  w_prod;
    logic [LIN_W-1:0]  w_lin_calc;
    logic [LIN_W:0]    w_mod_sub;
    logic              w_mod_ge;
    logic [SRC_AW-1:0] w_src_addr;
    logic              w_src_we;
    logic              w_src_re;
    logic              w_eor;
    logic              w_eof;
    logic [31:0]       w_pal_pixel;
    t_pal_req          w_pal_req;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Error settling: one destination-size subtract per cycle on each axis.
    assign w_row_more = r_row_err >= r_dh;
    assign w_col_more = r_col_err >= r_dw;

    // Linear source address of the settled position.
    assign w_prod     = LIN_W'(r_src_row) * LIN_W'(r_sw);
    assign w_lin_calc = w_prod + LIN_W'(r_src_col);

    // Restoring reduction modulo the store size, one shifted compare per cycle.
    assign w_mod_sub  = (LIN_W + 1)'(SOURCE_PIXELS) << (r_step - STEP_W'(1));
    assign w_mod_ge   = {1'b0, r_lin} >= w_mod_sub;
    assign w_src_addr = r_lin[SRC_AW-1:0];
    assign w_src_we   = (r_state == ST_MOD) && (r_step == '0) && r_is_wr;
    assign w_src_re   = (r_state == ST_MOD) && (r_step == '0) && !r_is_wr;

    // Last pixel of the row and of the frame.
    assign w_eor = {1'b0, r_dst_col} >= (r_dw - 13'd1);
    assign w_eof = w_eor && ({1'b0, r_dst_row} >= (r_dh - 13'd1));

    // Source index memory: one port, written or read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_src_we) begin
            r_src_mem[w_src_addr] <= r_wbyte;
        end
        if (w_src_re) begin
            r_src_q <= r_src_mem[w_src_addr];
        end
    end

    // Palette transactions: writes straight from the input, reads with the fetched index.
    always_comb begin
        w_pal_req.wr_en   = w_accept && (i_action == ACT_PAL_WR);
        w_pal_req.wr_addr = i_address;
        w_pal_req.wr_data = i_write_data;
        w_pal_req.rd_en   = (r_state == ST_PAL);
        w_pal_req.rd_idx  = r_src_q;
    end

    pnns_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_pal_req),
        .i_out_format(r_out_fmt),
        .o_pixel     (w_pal_pixel)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_action == ACT_SRC_WR)) begin
                    n_state = ST_MOD;
                end else if (w_accept && (i_action == ACT_PIXEL)) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                if (!w_row_more && !w_col_more) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (r_step == '0) begin
                    n_state = r_is_wr ? ST_IDLE : ST_PAL;
                end
            end
            ST_PAL:  n_state = ST_EMIT;
            ST_EMIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and walk position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sw      <= SRC_WIDTH_RST;
            r_sh      <= SRC_HEIGHT_RST;
            r_dw      <= DST_WIDTH_RST;
            r_dh      <= DST_HEIGHT_RST;
            r_out_fmt <= FMT_WORD32;
            r_src_col <= '0;
            r_src_row <= '0;
            r_col_err <= '0;
            r_row_err <= '0;
            r_dst_col <= '0;
            r_dst_row <= '0;
            r_is_wr   <= 1'b0;
            r_step    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;

            // A write to any listed register restarts the walk.
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_sw <= clamp_src_dim(i_cfg_data[10:0]);
                    CFG_SRC_HEIGHT: r_sh <= clamp_src_dim(i_cfg_data[10:0]);
                    CFG_DST_WIDTH:  r_dw <= clamp_dst_dim(i_cfg_data[12:0]);
                    CFG_DST_HEIGHT: r_dh <= clamp_dst_dim(i_cfg_data[12:0]);
                    CFG_OUT_FORMAT: r_out_fmt <= i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_index inside {[CFG_SRC_WIDTH:CFG_OUT_FORMAT]}) begin
                    r_src_col <= '0;
                    r_src_row <= '0;
                    r_col_err <= '0;
                    r_row_err <= '0;
                    r_dst_col <= '0;
                    r_dst_row <= '0;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_is_wr <= (i_action == ACT_SRC_WR);
                        r_step  <= STEP_W'(MOD_STEPS);
                    end
                end
                ST_SETTLE: begin
                    if (w_row_more) begin
                        r_row_err <= r_row_err - r_dh;
                        r_src_row <= r_src_row + 10'd1;
                    end
                    if (w_col_more) begin
                        r_col_err <= r_col_err - r_dw;
                        r_src_col <= r_src_col + 10'd1;
                    end
                end
                ST_MOD: begin
                    if (r_step != '0) begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    if (w_eof) begin
                        r_src_col <= '0;
                        r_src_row <= '0;
                        r_col_err <= '0;
                        r_row_err <= '0;
                        r_dst_col <= '0;
                        r_dst_row <= '0;
                    end else if (w_eor) begin
                        r_dst_col <= '0;
                        r_src_col <= '0;
                        r_col_err <= '0;
                        r_dst_row <= r_dst_row + 12'd1;
                        r_row_err <= r_row_err + 13'(r_sh);
                    end else begin
                        r_dst_col <= r_dst_col + 12'd1;
                        r_col_err <= r_col_err + 13'(r_sw);
                    end
                end
                default: ;
            endcase
        end
    end

    // Address register: loaded on accept or after settling, then reduced in place.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lin   <= LIN_W'(i_address);
            r_wbyte <= i_write_data[7:0];
        end else if ((r_state == ST_SETTLE) && !w_row_more && !w_col_more) begin
            r_lin <= w_lin_calc;
        end else if ((r_state == ST_MOD) && (r_step != '0) && w_mod_ge) begin
            r_lin <= LIN_W'({1'b0, r_lin} - w_mod_sub);
        end
    end

    // Result registers, loaded in the emit state and held until the next pixel.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT) begin
            r_pixel <= w_pal_pixel;
            r_eor   <= w_eor;
            r_eof   <= w_eof;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_pixel        = r_pixel;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "result strobe held")
    `ASSERT_IMPLIES(a_strobe_from_emit, i_clk, i_rst_n, o_strobe, $past(r_state == ST_EMIT), "strobe without emit")
    `ASSERT_IMPLIES(a_eof_is_eor, i_clk, i_rst_n, o_strobe && o_end_of_frame, o_end_of_row, "frame end off row end")
    `ASSERT_NEXT(a_settle_progress, i_clk, i_rst_n, (r_state == ST_SETTLE) && w_row_more, r_row_err < $past(r_row_err), "row error not reduced")
    `ASSERT_IMPLIES(a_addr_reduced, i_clk, i_rst_n, (r_state == ST_MOD) && (r_step == '0), POW2 || (r_lin < LIN_W'(SOURCE_PIXELS)), "source address not reduced")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the palette nearest-neighbor scaler with its pixel checker.
`timescale 1ns / 100ps

import pnns_pkg::*;

// One expected or observed output pixel.
typedef struct {
    logic [31:0] pixel;
    logic        eor;
    logic        eof;
} scaled_pixel_t;

// Tracks the palette, the index store and the raster walk, and checks each output pixel.
class pixel_checker;
    logic [10:0]   src_w, src_h;
    logic [12:0]   dst_w, dst_h;
    logic          fmt;
    logic [31:0]   palette [PALETTE_ENTRIES_DEF];
    logic [7:0]    source_mem [SOURCE_PIXELS_DEF];
    bit            written [SOURCE_PIXELS_DEF];
    logic [9:0]    scol, srow;
    logic [12:0]   cerr, rerr;
    logic [11:0]   dcol, drow;
    scaled_pixel_t expected_pixels [$];
    int            fails;

    function new();
        src_w = SRC_WIDTH_RST;
        src_h = SRC_HEIGHT_RST;
        dst_w = DST_WIDTH_RST;
        dst_h = DST_HEIGHT_RST;
        fmt   = FMT_WORD32;
        for (int i = 0; i < PALETTE_ENTRIES_DEF; i++) begin
            palette[i] = {8'd0, 8'(i), 8'(i), 8'(i)};
        end
        fails = 0;
        restart();
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function void restart();
        scol = '0;
        srow = '0;
        cerr = '0;
        rerr = '0;
        dcol = '0;
        drow = '0;
    endfunction

    // Bring the error accumulators onto the source pixel to show; repeating it is harmless.
    function void settle();
        int unsigned dw, dh;
        dw   = clamp_dim(32'(dst_w), 32'(DST_DIM_MAX));
        dh   = clamp_dim(32'(dst_h), 32'(DST_DIM_MAX));
        srow = 10'(32'(srow) + 32'(rerr) / dh);
        rerr = 13'(32'(rerr) % dh);
        scol = 10'(32'(scol) + 32'(cerr) / dw);
        cerr = 13'(32'(cerr) % dw);
    endfunction

    // Index store address that the next pixel request reads.
    function logic [15:0] read_address();
        settle();
        return 16'(32'(srow) * clamp_dim(32'(src_w), 32'(SRC_DIM_MAX)) + 32'(scol));
    endfunction

    function bit is_written(logic [15:0] addr);
        return written[addr];
    endfunction

    // Number of source entries covered by one frame, bounded by the store size.
    function int unsigned span();
        int unsigned n;
        n = clamp_dim(32'(src_w), 32'(SRC_DIM_MAX)) * clamp_dim(32'(src_h), 32'(SRC_DIM_MAX));
        return (n > SOURCE_PIXELS_DEF) ? SOURCE_PIXELS_DEF : n;
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function void write_register(logic [2:0] idx, logic [31:0] value);
        case (idx)
            CFG_SRC_WIDTH:  src_w = value[10:0];
            CFG_SRC_HEIGHT: src_h = value[10:0];
            CFG_DST_WIDTH:  dst_w = value[12:0];
            CFG_DST_HEIGHT: dst_h = value[12:0];
            CFG_OUT_FORMAT: fmt = value[0];
            default:        return;
        endcase
        restart();
    endfunction

    // Note one accepted input transaction and queue the pixel it produces, if any.
    function void take_item(logic [1:0] act, logic [15:0] addr, logic [31:0] data);
        logic [15:0]   lin;
        logic [31:0]   color;
        scaled_pixel_t px;
        int unsigned   sw, sh, dw, dh;
        case (act)
            ACT_PAL_WR: begin
                if (32'(addr) < PALETTE_ENTRIES_DEF) begin
                    palette[addr[7:0]] = data;
                end
            end
            ACT_SRC_WR: begin
                source_mem[addr] = data[7:0];
                written[addr] = 1'b1;
            end
            ACT_PIXEL: begin
                sw    = clamp_dim(32'(src_w), 32'(SRC_DIM_MAX));
                sh    = clamp_dim(32'(src_h), 32'(SRC_DIM_MAX));
                dw    = clamp_dim(32'(dst_w), 32'(DST_DIM_MAX));
                dh    = clamp_dim(32'(dst_h), 32'(DST_DIM_MAX));
                lin   = read_address();
                color = palette[source_mem[lin]];
                px.pixel = (fmt == FMT_RGB565) ?
                    {16'd0, color[23:19], color[15:10], color[7:3]} : color;
                cerr   = 13'(32'(cerr) + sw);
                px.eor = (32'(dcol) >= dw - 1);
                px.eof = px.eor && (32'(drow) >= dh - 1);
                if (px.eof) begin
                    restart();
                end else if (px.eor) begin
                    dcol = '0;
                    scol = '0;
                    cerr = '0;
                    drow = 12'(drow + 12'd1);
                    rerr = 13'(32'(rerr) + sh);
                end else begin
                    dcol = 12'(dcol + 12'd1);
                end
                expected_pixels.push_back(px);
            end
            default: ;
        endcase
    endfunction

    // Compare one output pixel with the oldest expected one.
    function void check_pixel(logic [31:0] pixel, logic eor, logic eof);
        scaled_pixel_t want;
        if (expected_pixels.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t: pixel %h eor %b eof %b with none expected",
                         $time, pixel, eor, eof);
            end
            return;
        end
        want = expected_pixels.pop_front();
        if (pixel !== want.pixel || eor !== want.eor || eof !== want.eof) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t: pixel %h eor %b eof %b, expected pixel %h eor %b eof %b",
                         $time, pixel, eor, eof, want.pixel, want.eor, want.eof);
            end
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] ACT_NONE  = 2'd3;
    localparam logic [2:0] CFG_SPARE = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = ACT_NONE;
    logic [15:0] i_address = '0;
    logic [31:0] i_write_data = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [31:0] o_pixel;
    logic        o_end_of_row;
    logic        o_end_of_frame;

    pixel_checker board;
    int           idle_pct = 0;
    int           sent_items = 0;

    palette_nearest_neighbor_scaler i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Every strobed pixel goes to the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_pixel(o_pixel, o_end_of_row, o_end_of_frame);
        end
    end

    // Drive one transaction and hold it until the block takes it; start stays high.
    task automatic send_item(input logic [1:0] act, input logic [15:0] addr,
                             input logic [31:0] data);
        start        <= 1'b1;
        i_action     <= act;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (busy);
        board.take_item(act, addr, data);
        sent_items++;
    endtask

    // Request a pixel, first filling the index entry it reads if it was never written.
    task automatic request_pixel();
        logic [15:0] addr;
        addr = board.read_address();
        if (!board.is_written(addr)) begin
            send_item(ACT_SRC_WR, addr, $urandom());
        end
        send_item(ACT_PIXEL, 16'($urandom()), $urandom());
    endtask

    // One register transaction; the caller lowers valid after the last one.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_register(idx, value);
    endtask

    // Stop sending and let every pending pixel come out, then a little more.
    task automatic wait_idle();
        start <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
    endtask

    // Set up a frame geometry; unused high data bits are filled with noise.
    task automatic program_frame(input int unsigned sw, input int unsigned sh,
                                 input int unsigned dw, input int unsigned dh,
                                 input logic fmt);
        wait_idle();
        cfg_write(CFG_SRC_WIDTH,  {21'($urandom()), 11'(sw)});
        cfg_write(CFG_SRC_HEIGHT, {21'($urandom()), 11'(sh)});
        cfg_write(CFG_DST_WIDTH,  {19'($urandom()), 13'(dw)});
        cfg_write(CFG_DST_HEIGHT, {19'($urandom()), 13'(dh)});
        cfg_write(CFG_OUT_FORMAT, {31'($urandom()), fmt});
        i_cfg_valid <= 1'b0;
    endtask

    // One random request, which may take two transactions for a pixel.
    task automatic random_item();
        int unsigned pick;
        logic [15:0] addr;
        pick = $urandom_range(99);
        if (pick < 55) begin
            request_pixel();
        end else if (pick < 75) begin
            addr = $urandom_range(1) ? 16'($urandom_range(board.span() - 1))
                                     : 16'($urandom());
            send_item(ACT_SRC_WR, addr, $urandom());
        end else if (pick < 92) begin
            send_item(ACT_PAL_WR, 16'($urandom_range(PALETTE_ENTRIES_DEF - 1)), $urandom());
        end else if (pick < 96) begin
            send_item(ACT_PAL_WR, 16'($urandom_range(65535, PALETTE_ENTRIES_DEF)),
                      $urandom());
        end else begin
            send_item(ACT_NONE, 16'($urandom()), $urandom());
        end
    endtask

    task automatic run_phase(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh,
                             input logic fmt, input int pct, input int count);
        int stop_at;
        int gap;
        program_frame(sw, sh, dw, dh, fmt);
        idle_pct = pct;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            gap = 0;
            while ($urandom_range(99) < idle_pct) begin
                gap++;
            end
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            random_item();
        end
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int pcts[3];
        board = new();
        pcts = '{0, 80, 7};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset geometry: 320x200 shown at 640x400, 32-bit words.
        send_item(ACT_SRC_WR, 16'h0000, 32'hFFFF_FF00);
        request_pixel();
        send_item(ACT_PAL_WR, 16'h0000, 32'hFFFF_FFFF);
        request_pixel();
        send_item(ACT_PAL_WR, 16'h00FF, 32'h0012_3456);
        send_item(ACT_SRC_WR, 16'h0001, 32'h0000_00FF);
        request_pixel();
        request_pixel();
        // Palette writes past the last entry are dropped.
        send_item(ACT_PAL_WR, 16'h0100, 32'h00AB_CDEF);
        send_item(ACT_PAL_WR, 16'hFFFF, 32'h0055_AA55);
        send_item(ACT_SRC_WR, 16'hFFFF, 32'hA5A5_A5AB);
        send_item(ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        request_pixel();

        // A write to an unused index, then RGB565 output restarting the walk.
        wait_idle();
        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_write(CFG_OUT_FORMAT, {31'h7FFF_FFFF, FMT_RGB565});
        i_cfg_valid <= 1'b0;
        repeat (4) request_pixel();

        // Extremes of the geometry registers, including zero and over-range values.
        run_phase(1, 1, 1, 1, FMT_RGB565, 0, 120);
        run_phase(0, 0, 0, 0, FMT_WORD32, 80, 120);
        run_phase(2047, 2047, 8191, 8191, FMT_RGB565, 7, 120);
        run_phase(1024, 1024, 4096, 4096, FMT_WORD32, 0, 60);
        // Strong shrinking: long accumulator settling per pixel.
        run_phase(1024, 1024, 2, 2, FMT_RGB565, 7, 60);
        // Source addresses that wrap around the store.
        run_phase(1000, 900, 7, 5, FMT_WORD32, 80, 120);
        run_phase(1024, 1024, 16, 3, FMT_RGB565, 0, 120);

        // Small random frames so rows and frames end often.
        for (int p = 0; p < 8; p++) begin
            run_phase($urandom_range(40, 1), $urandom_range(12, 1), $urandom_range(24, 1),
                      $urandom_range(24, 1), 1'($urandom_range(1)), pcts[p % 3], 120);
        end

        wait_idle();
        if (board.fails == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
